/* hw/rtl/isort_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types, mode codes and the compare rule of the insertion sort engine.
// ----------------------------------------------------------------------------
package isort_pkg;

  localparam int DATA_W = 32;
  localparam int SWAP_W = 11;
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_ASC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DESC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PART = 2'd2;

  localparam logic [1:0] ADDR_SORT_MODE = 2'd0;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_OUTER,
    ST_KEY,
    ST_CMP,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // true when the word at the upper slot must move below the one at the lower slot
  function automatic logic must_exchange(input logic [MODE_W-1:0] mode,
                                         input logic signed [DATA_W-1:0] upper,
                                         input logic signed [DATA_W-1:0] lower);
    logic res;
    case (mode)
      MODE_DESC: res = (lower < upper);
      MODE_PART: res = upper[DATA_W-1] & ~lower[DATA_W-1];
      MODE_ASC:  res = (upper < lower);
      default:   res = (upper < lower);
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/insertion_sort_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Collects a set of signed words, stable-insertion-sorts it, emits it in order.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_ready): one word per handshake, is_last ends
// the set. Loading accepts one word per cycle; words past MAX_ELEMENTS are
// dropped and flagged on every result of the set.
// After the last word the block is busy sorting: per element it fetches the
// key, makes one adjacent exchange per compare step, then places the key.
// The element memory has one write port and one registered read port, so
// each word is read into a register before it is compared.
// Output channel (result_valid/result_ready): n words in order, each read from
// memory, then loaded into the output register; a stalled receiver holds the
// output register and the sequencer waits. The next set may start loading
// while the final result still waits. swap_count/dropped match on all results.
// sort_mode lives at APB address 0: 0 ascending, 1 descending, 2 negatives
// first (stable), 3 ascending. Write it only while idle.
// Reset (rst, synchronous) empties the block and sets ascending mode.
// ----------------------------------------------------------------------------
module insertion_sort_engine #(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [1:0]                          paddr,
  input  wire  [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  wire                                 item_valid,
  output logic                                item_ready,
  input  wire  signed [isort_pkg::DATA_W-1:0] value,
  input  wire                                 is_last,
  output logic                                result_valid,
  input  wire                                 result_ready,
  output logic signed [isort_pkg::DATA_W-1:0] sorted_value,
  output logic                                end_of_set,
  output logic [isort_pkg::SWAP_W-1:0]        swap_count,
  output logic                                dropped
);
  import isort_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  state_t state, state_next;

  logic [MODE_W-1:0]        sort_mode;
  logic [CW-1:0]            count, count_next;
  logic                     overflow, overflow_next;
  logic [SWAP_W-1:0]        swaps, swaps_next;
  logic [CW-1:0]            sort_idx, sort_idx_next;
  logic [AW-1:0]            ptr, ptr_next;
  logic signed [DATA_W-1:0] key, key_next;
  logic [AW-1:0]            out_k, out_k_next;

  logic signed [DATA_W-1:0] mem [MAX_ELEMENTS];
  logic signed [DATA_W-1:0] rdata;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            waddr, raddr;
  logic signed [DATA_W-1:0] wdata;

  logic                     result_valid_next;
  logic signed [DATA_W-1:0] sorted_value_next;
  logic                     end_of_set_next;
  logic [SWAP_W-1:0]        swap_count_next;
  logic                     dropped_next;

  logic item_acc, exch, slot_free, emit_last, store_full, more_keys;
  logic [AW-1:0] ptr_m1;

  assign pready     = 1'b1;
  assign prdata     = (paddr == ADDR_SORT_MODE) ? {{(32-MODE_W){1'b0}}, sort_mode} : 32'd0;
  assign item_ready = (state == ST_LOAD);
  assign item_acc   = item_valid & item_ready;
  assign exch       = must_exchange(sort_mode, key, rdata);
  assign ptr_m1     = ptr - AW'(1);
  assign slot_free  = ~result_valid | result_ready;
  assign emit_last  = (CW'(out_k) == count - CW'(1));
  assign store_full = (count >= CW'(MAX_ELEMENTS));
  assign more_keys  = (sort_idx < count);

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_mode <= MODE_ASC;
    end else if (psel && penable && pwrite && pready) begin
      sort_mode <= pwdata[MODE_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:    if (item_acc && is_last) state_next = ST_OUTER;
      ST_OUTER:   state_next = more_keys ? ST_KEY : ST_EMIT_RD;
      ST_KEY:     state_next = ST_CMP;
      ST_CMP: begin
        if (!exch) state_next = ST_OUTER;
        else if (ptr_m1 == '0) state_next = ST_PLACE;
      end
      ST_PLACE:   state_next = ST_OUTER;
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: if (slot_free) state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
      default:    state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    count_next        = count;
    overflow_next     = overflow;
    swaps_next        = swaps;
    sort_idx_next     = sort_idx;
    ptr_next          = ptr;
    key_next          = key;
    out_k_next        = out_k;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    waddr             = ptr;
    wdata             = key;
    raddr             = sort_idx[AW-1:0];
    result_valid_next = result_valid & ~result_ready;
    sorted_value_next = sorted_value;
    end_of_set_next   = end_of_set;
    swap_count_next   = swap_count;
    dropped_next      = dropped;
    case (state)
      ST_LOAD: begin
        if (item_acc) begin
          if (!store_full) begin
            mem_we     = 1'b1;
            waddr      = count[AW-1:0];
            wdata      = value;
            count_next = count + CW'(1);
          end else begin
            overflow_next = 1'b1;
          end
          sort_idx_next = CW'(1);
        end
      end
      ST_OUTER: begin
        if (more_keys) begin
          mem_re = 1'b1;
          raddr  = sort_idx[AW-1:0];
        end else begin
          out_k_next = '0;
        end
      end
      ST_KEY: begin
        key_next = rdata;
        ptr_next = sort_idx[AW-1:0];
        mem_re   = 1'b1;
        raddr    = sort_idx[AW-1:0] - AW'(1);
      end
      ST_CMP: begin
        mem_we = 1'b1;
        waddr  = ptr;
        if (exch) begin
          wdata    = rdata;
          ptr_next = ptr_m1;
          if (swaps != '1) swaps_next = swaps + SWAP_W'(1);
          if (ptr_m1 != '0) begin
            mem_re = 1'b1;
            raddr  = ptr_m1 - AW'(1);
          end
        end else begin
          wdata         = key;
          sort_idx_next = sort_idx + CW'(1);
        end
      end
      ST_PLACE: begin
        mem_we        = 1'b1;
        waddr         = ptr;
        wdata         = key;
        sort_idx_next = sort_idx + CW'(1);
      end
      ST_EMIT_RD: begin
        mem_re = 1'b1;
        raddr  = out_k;
      end
      ST_EMIT_LD: begin
        if (slot_free) begin
          result_valid_next = 1'b1;
          sorted_value_next = rdata;
          end_of_set_next   = emit_last;
          swap_count_next   = swaps;
          dropped_next      = overflow;
          out_k_next        = out_k + AW'(1);
          if (emit_last) begin
            count_next    = '0;
            swaps_next    = '0;
            overflow_next = 1'b0;
          end
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      count        <= '0;
      overflow     <= 1'b0;
      swaps        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      overflow     <= overflow_next;
      swaps        <= swaps_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sort_idx     <= sort_idx_next;
    ptr          <= ptr_next;
    key          <= key_next;
    out_k        <= out_k_next;
    sorted_value <= sorted_value_next;
    end_of_set   <= end_of_set_next;
    swap_count   <= swap_count_next;
    dropped      <= dropped_next;
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_cmp_ptr: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> ptr != '0)
    else $error("compare step at bottom slot");

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == ST_LOAD) |-> !store_full)
    else $error("store write while full");

  a_last_sorts: assert property (@(posedge clk) disable iff (rst)
    (item_acc && is_last) |=> (state == ST_OUTER && count != '0))
    else $error("last word did not start an empty-free sort");

endmodule
`default_nettype wire
